/* rtl/mlvg_pkg.sv */
package mlvg_pkg;

  localparam int FRAC_W    = 15;
  localparam int MAX_DIM   = 1024;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SIN_LAT   = 8;
  localparam int HORNER_N  = 4;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] SIN_A9  = 32'd172272;
  localparam logic [31:0] SIN_COEF [HORNER_N] =
    '{32'd5026995, 32'd85569306, 32'd693598667, 32'd1686629713};

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_FREQ   = 3'd4;

endpackage

/* rtl/marschner_lobb_voxel_generator_unit.sv */
// channel | signals                                   | content
// in      | in_tvalid in_tready in_tdata[31:0]        | request: pos_x, pos_y, pos_z
// out     | out_tvalid out_tready out_tdata out_tuser | sample; index_error
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
// One request enters per cycle while the pipeline is not frozen; each request passes
// through 68 pipeline stages, set by the coordinate divider, the square root and two
// chained sine units, and then the output register before its result leaves.
// rst_n (synchronous) clears the valid bits and loads the register defaults.
// A two-entry output register and skid stage hold results; the pipeline
// freezes only while both are full.
module marschner_lobb_voxel_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] pos_x, [19:10] pos_y, [29:20] pos_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] sample
  output logic [0:0]  out_tuser,  // [0] index_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int F      = mlvg_pkg::FRAC_W;
  localparam int NW     = mlvg_pkg::SIZE_W;
  localparam int PSW    = mlvg_pkg::POS_W;
  localparam int RGW    = mlvg_pkg::REG_W;
  localparam int SLAT   = mlvg_pkg::SIN_LAT;
  localparam int QW     = F + 1;
  localparam int CW     = QW + 1;
  localparam int DW     = 2 * NW + F + 2;
  localparam int DDW    = 2 * NW + 1;
  localparam int R2W    = 2 * QW + 1;
  localparam int RW     = QW + 1;
  localparam int TW     = 2 * RW;
  localparam int SDIV   = 8;
  localparam int AW     = RGW + 32;
  localparam int NUMW   = AW + 1;
  localparam int BIGW   = NUMW + 9;
  localparam int UW     = NUMW;
  localparam int LAT    = QW + RW + 2 * SLAT + SDIV + 11;
  localparam int CZ_DLY = RW + SLAT + 2;

  logic [NW-1:0]  size_r [3];
  logic [RGW-1:0] weight_r;
  logic [RGW-1:0] freq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= NW'(64);
      size_r[1] <= NW'(64);
      size_r[2] <= NW'(64);
      weight_r  <= RGW'(1024);
      freq_r    <= RGW'(1536);
    end else if (cfg_valid) begin
      case (cfg_index)
        mlvg_pkg::CFG_SIZE_X:     size_r[0] <= cfg_data[NW-1:0];
        mlvg_pkg::CFG_SIZE_Y:     size_r[1] <= cfg_data[NW-1:0];
        mlvg_pkg::CFG_SIZE_Z:     size_r[2] <= cfg_data[NW-1:0];
        mlvg_pkg::CFG_MOD_WEIGHT: weight_r  <= cfg_data[RGW-1:0];
        mlvg_pkg::CFG_MOD_FREQ:   freq_r    <= cfg_data[RGW-1:0];
        default: ;
      endcase
    end
  end

  logic            adv;
  logic            skid_v_r;
  logic [LAT-1:0]  v_r;
  logic [LAT-1:0]  e_r;

  assign adv       = ~skid_v_r;
  assign in_tready = adv;

  // coordinate front end
  logic [NW-1:0]  neff [3];
  logic [PSW-1:0] pos_nxt [3];
  logic           err_nxt;
  logic [PSW-1:0] pos_r [3];
  logic [NW-1:0]  t2 [3];
  logic [NW-1:0]  mag2 [3];
  logic [2*NW-1:0] mn_nxt [3];
  logic [2*NW-1:0] nn_nxt [3];
  logic           neg_nxt [3];
  logic           flat_nxt [3];
  logic [2*NW-1:0] mn_r [3];
  logic [2*NW-1:0] nn_r [3];
  logic           neg_r [QW+2][3];
  logic           flat_r [QW+2][3];
  logic [2*NW-1:0] den3 [3];

  logic [DW-1:0]  rem_r [QW][3];
  logic [DDW-1:0] dd_r [QW][3];
  logic [QW-1:0]  q_r [QW+1][3];
  logic [DW-1:0]  rem_nxt [QW][3];
  logic [QW-1:0]  q_nxt [QW][3];

  always_comb begin
    err_nxt = 1'b0;
    for (int d = 0; d < 3; d++) begin
      neff[d] = (size_r[d] > NW'(mlvg_pkg::MAX_DIM)) ? NW'(mlvg_pkg::MAX_DIM) : size_r[d];
      pos_nxt[d] = in_tdata[d*PSW +: PSW];
      if (NW'(pos_nxt[d]) >= neff[d]) err_nxt = 1'b1;
      t2[d] = NW'({pos_r[d], 1'b1});
      neg_nxt[d] = t2[d] < neff[d];
      mag2[d] = neg_nxt[d] ? (neff[d] - t2[d]) : (t2[d] - neff[d]);
      mn_nxt[d] = (2*NW)'(mag2[d]) * (2*NW)'(neff[d]);
      nn_nxt[d] = (2*NW)'(neff[d]) * (2*NW)'(neff[d]);
      flat_nxt[d] = neff[d] <= NW'(1);
      den3[d] = nn_r[d] - (2*NW)'(1);
    end
  end

  always_comb begin
    logic [DW-1:0] sh;
    for (int j = 0; j < QW; j++) begin
      for (int d = 0; d < 3; d++) begin
        sh = DW'(dd_r[j][d]) << (QW - 1 - j);
        if (rem_r[j][d] >= sh) begin
          rem_nxt[j][d] = rem_r[j][d] - sh;
          q_nxt[j][d] = q_r[j][d] | (QW'(1) << (QW - 1 - j));
        end else begin
          rem_nxt[j][d] = rem_r[j][d];
          q_nxt[j][d] = q_r[j][d];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 3; d++) begin
        pos_r[d] <= pos_nxt[d];
        mn_r[d] <= mn_nxt[d];
        nn_r[d] <= nn_nxt[d];
        neg_r[0][d] <= neg_nxt[d];
        flat_r[0][d] <= flat_nxt[d];
        for (int i = 1; i < QW + 2; i++) begin
          neg_r[i][d] <= neg_r[i-1][d];
          flat_r[i][d] <= flat_r[i-1][d];
        end
        rem_r[0][d] <= (DW'(mn_r[d]) << (F + 1)) + DW'(den3[d]);
        dd_r[0][d] <= {den3[d], 1'b0};
        q_r[0][d] <= '0;
        for (int j = 0; j < QW; j++) begin
          q_r[j+1][d] <= q_nxt[j][d];
          if (j < QW - 1) begin
            rem_r[j+1][d] <= rem_nxt[j][d];
            dd_r[j+1][d] <= dd_r[j][d];
          end
        end
      end
    end
  end

  // radius
  logic [QW-1:0]       cmag [3];
  logic signed [CW-1:0] cz_nxt;
  logic [2*QW-1:0]     sq_r [2];
  logic signed [CW-1:0] cz_r;
  logic [R2W-1:0]      rrem_r [RW];
  logic [RW-1:0]       root_r [RW+1];
  logic [R2W-1:0]      rrem_nxt [RW];
  logic [RW-1:0]       root_nxt [RW];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      cmag[d] = flat_r[QW+1][d] ? '0 : q_r[QW][d];
    end
    cz_nxt = neg_r[QW+1][2] ? -$signed(CW'(cmag[2])) : $signed(CW'(cmag[2]));
  end

  always_comb begin
    logic [TW-1:0] trial;
    for (int j = 0; j < RW; j++) begin
      trial = (TW'(root_r[j]) << (RW - j)) | (TW'(1) << (2 * (RW - 1 - j)));
      if (TW'(rrem_r[j]) >= trial) begin
        rrem_nxt[j] = rrem_r[j] - R2W'(trial);
        root_nxt[j] = root_r[j] | (RW'(1) << (RW - 1 - j));
      end else begin
        rrem_nxt[j] = rrem_r[j];
        root_nxt[j] = root_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= (2*QW)'(cmag[0]) * (2*QW)'(cmag[0]);
      sq_r[1] <= (2*QW)'(cmag[1]) * (2*QW)'(cmag[1]);
      cz_r <= cz_nxt;
      rrem_r[0] <= R2W'(sq_r[0]) + R2W'(sq_r[1]);
      root_r[0] <= '0;
      for (int j = 0; j < RW; j++) begin
        root_r[j+1] <= root_nxt[j];
        if (j < RW - 1) rrem_r[j+1] <= rrem_nxt[j];
      end
    end
  end

  // trig section
  logic [31:0]         ph_a;
  logic signed [31:0]  c1;
  logic signed [48:0]  fs_x;
  logic signed [48:0]  c1_x;
  logic signed [48:0]  prodf;
  logic [31:0]         ph2_r;
  logic signed [CW-1:0] cz_dl_r [CZ_DLY];
  logic [31:0]         czx;
  logic signed [31:0]  cr;
  logic signed [31:0]  sz;

  assign ph_a  = (32'(root_r[RW]) << (30 - F)) + mlvg_pkg::Q30_ONE;
  assign fs_x  = $signed({{(49-RGW){1'b0}}, freq_r});
  assign c1_x  = $signed({{17{c1[31]}}, c1});
  assign prodf = fs_x * c1_x;
  assign czx   = {{(32-CW){cz_dl_r[CZ_DLY-1][CW-1]}}, cz_dl_r[CZ_DLY-1]} << (30 - F);

  mlvg_sine u_cos_r (
    .clk     (clk),
    .en      (adv),
    .phase   (ph_a),
    .sin_val (c1)
  );

  mlvg_sine u_cos_m (
    .clk     (clk),
    .en      (adv),
    .phase   (ph2_r + mlvg_pkg::Q30_ONE),
    .sin_val (cr)
  );

  mlvg_sine u_sin_z (
    .clk     (clk),
    .en      (adv),
    .phase   (czx),
    .sin_val (sz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ph2_r <= prodf[37:6];
      cz_dl_r[0] <= cz_r;
      for (int i = 1; i < CZ_DLY; i++) cz_dl_r[i] <= cz_dl_r[i-1];
    end
  end

  // density and quantizer
  logic [31:0]      crp;
  logic [31:0]      zs_nxt;
  logic [AW-1:0]    a_r;
  logic [31:0]      zs_r;
  logic [NUMW-1:0]  num_r;
  logic [BIGW-1:0]  big_r;
  logic [17:0]      den18;
  logic [UW-1:0]    unit_r;
  logic [BIGW-1:0]  srem_r [SDIV];
  logic [UW-1:0]    sunit_r [SDIV];
  logic [SDIV-1:0]  sdq_r [SDIV+1];
  logic             ov_r [SDIV+1];
  logic [BIGW-1:0]  srem_nxt [SDIV];
  logic [SDIV-1:0]  sdq_nxt [SDIV];
  logic [7:0]       smp_nxt;
  logic [7:0]       smp_r;

  assign crp    = mlvg_pkg::Q30_ONE + $unsigned(cr);
  assign zs_nxt = mlvg_pkg::Q30_ONE - $unsigned(sz);
  assign den18  = (18'(weight_r) + 18'd4096) << 1;

  always_comb begin
    logic [BIGW-1:0] sh;
    for (int j = 0; j < SDIV; j++) begin
      sh = BIGW'(sunit_r[j]) << (SDIV - 1 - j);
      if (srem_r[j] >= sh) begin
        srem_nxt[j] = srem_r[j] - sh;
        sdq_nxt[j] = sdq_r[j] | (SDIV'(1) << (SDIV - 1 - j));
      end else begin
        srem_nxt[j] = srem_r[j];
        sdq_nxt[j] = sdq_r[j];
      end
    end
    if (e_r[LAT-2]) begin
      smp_nxt = '0;
    end else if (ov_r[SDIV] || (sdq_r[SDIV] == 8'hFF)) begin
      smp_nxt = 8'hFF;
    end else begin
      smp_nxt = sdq_r[SDIV] + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= AW'(weight_r) * AW'(crp);
      zs_r <= zs_nxt;
      num_r <= (NUMW'(zs_r) << 12) + NUMW'(a_r);
      big_r <= (BIGW'(num_r) << 9) - (BIGW'(num_r) << 1);
      unit_r <= UW'(den18) << 31;
      ov_r[0] <= big_r >= (BIGW'(unit_r) << SDIV);
      srem_r[0] <= big_r;
      sunit_r[0] <= unit_r;
      sdq_r[0] <= '0;
      for (int j = 0; j < SDIV; j++) begin
        sdq_r[j+1] <= sdq_nxt[j];
        ov_r[j+1] <= ov_r[j];
        if (j < SDIV - 1) begin
          srem_r[j+1] <= srem_nxt[j];
          sunit_r[j+1] <= sunit_r[j];
        end
      end
      smp_r <= smp_nxt;
      e_r <= {e_r[LAT-2:0], err_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // output register and skid stage
  logic       deliver;
  logic       out_v_r;
  logic [7:0] out_smp_r;
  logic       out_err_r;
  logic [7:0] skid_smp_r;
  logic       skid_err_r;

  assign deliver = adv & v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (deliver) begin
        skid_v_r   <= 1'b1;
        skid_smp_r <= smp_r;
        skid_err_r <= e_r[LAT-1];
      end
    end else if (skid_v_r) begin
      out_v_r   <= 1'b1;
      out_smp_r <= skid_smp_r;
      out_err_r <= skid_err_r;
      skid_v_r  <= 1'b0;
    end else begin
      out_v_r   <= deliver;
      out_smp_r <= smp_r;
      out_err_r <= e_r[LAT-1];
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_smp_r;
  assign out_tuser[0] = out_err_r;

endmodule

/* rtl/mlvg_sine.sv */
module mlvg_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] sin_val
);

  localparam int XW = 31;
  localparam int PW = 31;
  localparam int MW = 62;
  localparam int HN = mlvg_pkg::HORNER_N;

  logic [XW-1:0]      x_r [6];
  logic [1:0]         q_r [7];
  logic [XW-1:0]      x2_r [HN];
  logic [PW-1:0]      p_r [HN];
  logic [31:0]        s_r;
  logic signed [31:0] sin_r;

  logic [XW-1:0]      x_nxt;
  logic [XW-1:0]      x2_nxt;
  logic [MW-1:0]      sq_full;
  logic [MW-1:0]      fin_full;
  logic [MW-1:0]      hm [HN];
  logic [PW-1:0]      p_nxt [HN];
  logic [31:0]        s_nxt;
  logic [31:0]        sat;
  logic signed [31:0] sin_nxt;

  always_comb begin
    x_nxt = phase[30] ? XW'(mlvg_pkg::Q30_ONE - {2'b00, phase[29:0]}) : {1'b0, phase[29:0]};
    sq_full = MW'(x_r[0]) * MW'(x_r[0]);
    x2_nxt = sq_full[60:30];
    hm[0] = MW'(mlvg_pkg::SIN_A9) * MW'(x2_r[0]);
    p_nxt[0] = PW'(mlvg_pkg::SIN_COEF[0] - hm[0][61:30]);
    for (int k = 1; k < HN; k++) begin
      hm[k] = MW'(p_r[k-1]) * MW'(x2_r[k]);
      p_nxt[k] = PW'(mlvg_pkg::SIN_COEF[k] - hm[k][61:30]);
    end
    fin_full = MW'(p_r[HN-1]) * MW'(x_r[5]);
    s_nxt = fin_full[61:30];
    sat = (s_r > mlvg_pkg::Q30_ONE) ? mlvg_pkg::Q30_ONE : s_r;
    sin_nxt = q_r[6][1] ? -$signed(sat) : $signed(sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_nxt;
      q_r[0] <= phase[31:30];
      for (int i = 1; i < 6; i++) x_r[i] <= x_r[i-1];
      for (int i = 1; i < 7; i++) q_r[i] <= q_r[i-1];
      x2_r[0] <= x2_nxt;
      for (int k = 0; k < HN - 1; k++) x2_r[k+1] <= x2_r[k];
      for (int k = 0; k < HN; k++) p_r[k] <= p_nxt[k];
      s_r <= s_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign sin_val = sin_r;

endmodule
